// ===== rtl/mqf_pkg.sv =====
// Shared constants, codes and the command type of the multi-queue FIFO.
package mqf_pkg;

  // Size of the queue bank.
  localparam int NUM_QUEUES  = 10;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  // Port widths fixed by the item and result formats.
  localparam int OP_W     = 2;
  localparam int QIN_W    = 4;
  localparam int IDIN_W   = 16;
  localparam int LEN_W    = 5;
  localparam int SERVED_W = 16;
  localparam int STAT_W   = 2;

  // Derived internal widths.
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_W = (ID_WIDTH < IDIN_W) ? ID_WIDTH : IDIN_W;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic [QW-1:0]        q;
    logic [STORE_W-1:0]   id;
  } cmd_t;

endpackage

// ===== rtl/mqf_front.sv =====
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
module mqf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mqf_pkg::OP_W-1:0]    opcode,
  input  logic [mqf_pkg::QIN_W-1:0]   queue_index,
  input  logic [mqf_pkg::IDIN_W-1:0]  item_id,
  output logic                        cmd_valid,
  output mqf_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);
  import mqf_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       accept;

  // Classify the incoming beat; an out-of-range queue is parked on queue zero.
  always_comb begin
    cls.op       = op_t'(opcode);
    cls.in_range = (32'(queue_index) < NUM_QUEUES);
    cls.q        = cls.in_range ? QW'(queue_index) : '0;
    cls.id       = STORE_W'(item_id);
  end

  assign full      = (fill == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  // Two-entry command queue between the front and the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        slot[wr_ptr] <= cls;
        wr_ptr       <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (accept && !cmd_pop) begin
        fill <= fill + 2'd1;
      end else if (cmd_pop && !accept) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/mqf_back.sv =====
// Back end: per-queue ring state, the item store and the result register.
module mqf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  mqf_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [mqf_pkg::LEN_W-1:0]     queue_length,
  output logic [mqf_pkg::SERVED_W-1:0]  served_count,
  output logic                          head_valid,
  output logic [mqf_pkg::IDIN_W-1:0]    head_id,
  output logic [mqf_pkg::STAT_W-1:0]    status
);
  import mqf_pkg::*;

  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t  state;

  // Per-queue ring state.
  logic [SW-1:0]       head_ptr [NUM_QUEUES];
  logic [SW-1:0]       tail_ptr [NUM_QUEUES];
  logic [CW-1:0]       count    [NUM_QUEUES];
  logic [SERVED_W-1:0] served   [NUM_QUEUES];

  // Item store with a registered read port.
  logic [STORE_W-1:0]  item_store [MEM_DEPTH];
  logic [ADDR_W-1:0]   rd_addr;
  logic [STORE_W-1:0]  rd_data;

  // Pending result fields.
  logic [LEN_W-1:0]    res_len;
  logic [SERVED_W-1:0] res_served;
  logic                res_head_valid;
  status_t             res_status;

  logic                out_full;
  status_t             out_status;

  logic [SW-1:0]       cur_head;
  logic [SW-1:0]       cur_tail;
  logic [CW-1:0]       cur_cnt;
  logic [SERVED_W-1:0] cur_served;
  logic [SW-1:0]       head_next;
  logic [SW-1:0]       tail_next;
  logic [CW-1:0]       cnt_next;
  logic [SERVED_W-1:0] served_next;
  status_t             op_status;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   head_addr;
  logic                take;
  logic                load;

  function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] s);
    ring_next = (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [QW-1:0] q,
                                                   input logic [SW-1:0] s);
    store_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(s);
  endfunction

  assign cur_head   = head_ptr[cmd.q];
  assign cur_tail   = tail_ptr[cmd.q];
  assign cur_cnt    = count[cmd.q];
  assign cur_served = served[cmd.q];

  // Work out the new state of the addressed queue.
  always_comb begin
    head_next   = cur_head;
    tail_next   = cur_tail;
    cnt_next    = cur_cnt;
    served_next = cur_served;
    op_status   = ST_OK;
    wr_en       = 1'b0;
    unique case (cmd.op)
      OP_CLEAR: begin
        head_next   = '0;
        tail_next   = '0;
        cnt_next    = '0;
        served_next = '0;
      end
      OP_APPEND: begin
        if (cur_cnt == CW'(QUEUE_DEPTH)) begin
          op_status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_next = ring_next(cur_tail);
          cnt_next  = cur_cnt + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (cur_cnt == '0) begin
          op_status = ST_EMPTY;
        end else begin
          head_next = ring_next(cur_head);
          cnt_next  = cur_cnt - CW'(1);
          if (cur_served != {SERVED_W{1'b1}}) begin
            served_next = cur_served + SERVED_W'(1);
          end
        end
      end
      OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  assign take      = (state == S_IDLE) && cmd_valid;
  assign cmd_pop   = take;
  assign wr_addr   = store_addr(cmd.q, cur_tail);
  assign head_addr = store_addr(cmd.q, head_next);
  assign load      = (state == S_DONE) && (!out_full || pop);

  // Item store: write on an append, and a registered read of the head slot.
  always_ff @(posedge clk) begin
    if (take && wr_en && cmd.in_range) begin
      item_store[wr_addr] <= cmd.id;
    end
    rd_data <= item_store[rd_addr];
  end

  // Sequencer, per-queue state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] <= '0;
        tail_ptr[i] <= '0;
        count[i]    <= '0;
        served[i]   <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (cmd.in_range) begin
              head_ptr[cmd.q] <= head_next;
              tail_ptr[cmd.q] <= tail_next;
              count[cmd.q]    <= cnt_next;
              served[cmd.q]   <= served_next;
            end
            rd_addr        <= head_addr;
            res_len        <= cmd.in_range ? LEN_W'(cnt_next) : '0;
            res_served     <= cmd.in_range ? served_next : '0;
            res_head_valid <= cmd.in_range && (cnt_next != '0);
            res_status     <= cmd.in_range ? op_status : ST_OK;
            state          <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Output register holds one result beat until it is popped.
      if (load) begin
        out_full     <= 1'b1;
        queue_length <= res_len;
        served_count <= res_served;
        head_valid   <= res_head_valid;
        head_id      <= res_head_valid ? IDIN_W'(rd_data) : '0;
        out_status   <= res_status;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  assign empty  = !out_full;
  assign status = out_status;

endmodule

// ===== rtl/multi_queue_fifo_top.sv =====
// Top level of the multi-queue FIFO: front end, command queue and back end.
//
//  Channel  | Handshake            | Beat contents
//  ---------+----------------------+-------------------------------------------------
//  input    | push / full          | opcode, queue_index, item_id
//  result   | empty / pop          | queue_length, served_count, head_valid, head_id,
//           |                      | status
//
// The back end takes each beat through three steps (update, item store read, result load),
// and does not take a new beat before the result of the last one is loaded. The front holds
// up to two classified beats; full is high when both slots are taken. Synchronous reset
// clears the pointers, counts and served counters; the item store is not cleared. A result
// waiting to be popped stalls the back end, while the front keeps accepting until its queue
// fills.
module multi_queue_fifo_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [mqf_pkg::OP_W-1:0]      opcode,
  input  logic [mqf_pkg::QIN_W-1:0]     queue_index,
  input  logic [mqf_pkg::IDIN_W-1:0]    item_id,
  output logic                          empty,
  input  logic                          pop,
  output logic [mqf_pkg::LEN_W-1:0]     queue_length,
  output logic [mqf_pkg::SERVED_W-1:0]  served_count,
  output logic                          head_valid,
  output logic [mqf_pkg::IDIN_W-1:0]    head_id,
  output logic [mqf_pkg::STAT_W-1:0]    status
);
  import mqf_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Accept and classify input beats.
  mqf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .queue_index (queue_index),
    .item_id     (item_id),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // Carry out each command and present its result.
  mqf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .queue_length (queue_length),
    .served_count (served_count),
    .head_valid   (head_valid),
    .head_id      (head_id),
    .status       (status)
  );

endmodule
